// ===== rtl/core/wsrm_pkg.sv =====
// Package for the wildcard star regex matcher: request codes, pattern bytes
// and token store sizing. No dependencies.
`timescale 1ns / 1ps

package wsrm_pkg;

  // Token store capacity (1 to 256).
  localparam int MaxTokens = 16;
  // Count of stored tokens, 0..MaxTokens.
  localparam int TokCntW = $clog2(MaxTokens + 1);
  // Index of one token slot.
  localparam int TokIdxW = (MaxTokens > 1) ? $clog2(MaxTokens) : 1;

  localparam logic [7:0] ChAny  = 8'h2E;
  localparam logic [7:0] ChStar = 8'h2A;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_END     = 2'd3
  } req_type_t;

endpackage

// ===== rtl/core/wsrm_if.sv =====
// Valid/ready channel interfaces for the regex matcher requests and results.
// Depends on wsrm_pkg.
`timescale 1ns / 1ps

interface wsrm_in_if;
  logic                valid;
  logic                ready;
  wsrm_pkg::req_type_t req_type;
  logic [7:0]          char_value;

  modport source (output valid, output req_type, output char_value, input ready);
  modport sink   (input valid, input req_type, input char_value, output ready);
endinterface

interface wsrm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== rtl/core/wildcard_star_regex_matcher.sv =====
// Whole-string matcher for patterns with '.' and '*', kept as an NFA bit set.
// Depends on wsrm_pkg and the channel interfaces in wsrm_if.sv.
`timescale 1ns / 1ps

// Channel   Dir  Payload                       Accepted when
// in_ch     in   req_type, char_value          in_ch.valid && in_ch.ready
// out_ch    out  matched, pattern_overflow     out_ch.valid && out_ch.ready
//
// Each request is handled combinationally: the token store, the active position
// set and the closure over starred tokens are registered when it is accepted.
// Only an end-of-text request produces a result; results sit in a two-entry
// output queue, so requests keep flowing while one result waits.
// in_ch.ready drops only when both queue entries are full.
// Reset (rst_n low, synchronous) empties the pattern, the queue and the set.

module wildcard_star_regex_matcher (
  input  logic          clk,
  input  logic          rst_n,
  wsrm_in_if.sink       in_ch,
  wsrm_out_if.source    out_ch
);

  localparam int NPos = wsrm_pkg::MaxTokens + 1;

  // Token store, only read below the token count.
  logic [7:0]                   tok_char_r [wsrm_pkg::MaxTokens];
  logic [wsrm_pkg::MaxTokens-1:0] tok_star_r;
  logic [wsrm_pkg::MaxTokens-1:0] tok_any_r;

  logic [wsrm_pkg::TokCntW-1:0] tok_cnt_r, tok_cnt_nxt;
  logic [NPos-1:0]              active_r, active_nxt;
  logic                         started_r, started_nxt;
  logic                         ovf_r, ovf_nxt;

  // Result queue.
  logic [1:0] res_match_r, res_ovf_r;
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] q_cnt_r, q_cnt_nxt;

  logic                         in_fire, push, pop;
  logic [wsrm_pkg::MaxTokens-1:0] tok_valid;
  logic [NPos-1:0]              start_set, cur_set, step_set, next_set;
  logic [wsrm_pkg::TokIdxW-1:0] last_idx, fill_idx;
  logic                         star_ok, cnt_full, hit;
  logic                         tok_wr, star_wr;

  // Starred positions that are active also activate the position after them.
  function automatic logic [NPos-1:0] close_set(
    input logic [NPos-1:0]                set_in,
    input logic [wsrm_pkg::MaxTokens-1:0] star,
    input logic [wsrm_pkg::MaxTokens-1:0] valid
  );
    logic [NPos-1:0] s;
    s = set_in;
    for (int i = 0; i < wsrm_pkg::MaxTokens; i++) begin
      if (s[i] && star[i] && valid[i]) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  assign in_ch.ready = (q_cnt_r != 2'd2);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign push        = in_fire && (in_ch.req_type == wsrm_pkg::REQ_END);

  always_comb begin
    for (int i = 0; i < wsrm_pkg::MaxTokens; i++) begin
      tok_valid[i] = (wsrm_pkg::TokCntW'(i) < tok_cnt_r);
    end
  end

  assign start_set = close_set({{(NPos-1){1'b0}}, 1'b1}, tok_star_r, tok_valid);
  assign cur_set   = started_r ? active_r : start_set;

  always_comb begin
    step_set = '0;
    for (int i = 0; i < wsrm_pkg::MaxTokens; i++) begin
      if (cur_set[i] && tok_valid[i] &&
          (tok_any_r[i] || (tok_char_r[i] == in_ch.char_value))) begin
        if (tok_star_r[i]) begin
          step_set[i] = 1'b1;
        end else begin
          step_set[i+1] = 1'b1;
        end
      end
    end
  end

  assign next_set = close_set(step_set, tok_star_r, tok_valid);

  assign last_idx = wsrm_pkg::TokIdxW'(tok_cnt_r - wsrm_pkg::TokCntW'(1));
  assign fill_idx = wsrm_pkg::TokIdxW'(tok_cnt_r);
  assign cnt_full = (tok_cnt_r == wsrm_pkg::TokCntW'(wsrm_pkg::MaxTokens));
  assign star_ok  = (in_ch.char_value == wsrm_pkg::ChStar) &&
                    (tok_cnt_r != '0) && !tok_star_r[last_idx];
  assign hit      = cur_set[tok_cnt_r] && !ovf_r;

  always_comb begin
    tok_cnt_nxt = tok_cnt_r;
    active_nxt  = active_r;
    started_nxt = started_r;
    ovf_nxt     = ovf_r;
    tok_wr      = 1'b0;
    star_wr     = 1'b0;
    if (in_fire) begin
      unique case (in_ch.req_type)
        wsrm_pkg::REQ_CLEAR: begin
          tok_cnt_nxt = '0;
          ovf_nxt     = 1'b0;
          active_nxt  = '0;
          started_nxt = 1'b0;
        end
        wsrm_pkg::REQ_PATTERN: begin
          active_nxt  = '0;
          started_nxt = 1'b0;
          if (star_ok) begin
            star_wr = 1'b1;
          end else if (!cnt_full) begin
            tok_wr      = 1'b1;
            tok_cnt_nxt = tok_cnt_r + wsrm_pkg::TokCntW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        wsrm_pkg::REQ_TEXT: begin
          active_nxt  = next_set;
          started_nxt = 1'b1;
        end
        wsrm_pkg::REQ_END: begin
          active_nxt  = '0;
          started_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_cnt_r <= '0;
      active_r  <= '0;
      started_r <= 1'b0;
      ovf_r     <= 1'b0;
      q_cnt_r   <= 2'd0;
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
    end else begin
      tok_cnt_r <= tok_cnt_nxt;
      active_r  <= active_nxt;
      started_r <= started_nxt;
      ovf_r     <= ovf_nxt;
      q_cnt_r   <= q_cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_wr) begin
      tok_char_r[fill_idx] <= in_ch.char_value;
      tok_star_r[fill_idx] <= 1'b0;
      tok_any_r[fill_idx]  <= (in_ch.char_value == wsrm_pkg::ChAny);
    end
    if (star_wr) begin
      tok_star_r[last_idx] <= 1'b1;
    end
    if (push) begin
      res_match_r[wr_ptr_r] <= hit;
      res_ovf_r[wr_ptr_r]   <= ovf_r;
    end
  end

  assign out_ch.valid            = (q_cnt_r != 2'd0);
  assign out_ch.matched          = res_match_r[rd_ptr_r];
  assign out_ch.pattern_overflow = res_ovf_r[rd_ptr_r];

endmodule
